### design/pat3d_pkg.sv
// ----------------------------------------------------------------------------
// pat3d_pkg: shared types, constants and sine table for the 3D point transform
// Fixed-point formats, command codes, the quarter-wave sine table (built at
// elaboration) and the angle-to-sine lookup.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pat3d_pkg;

  // Table depth and fraction bits of the Q format
  localparam int unsigned SINE_TABLE_DEPTH = 256;
  localparam int unsigned FRAC_BITS        = 16;

  // Field widths
  localparam int unsigned COORD_W  = 32;
  localparam int unsigned ANGLE_W  = 16;
  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned QUARTER_BITS = 14;

  // Derived widths
  localparam int unsigned IDX_W    = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int unsigned SINE_W   = FRAC_BITS + 1;      // table magnitude, up to 1.0
  localparam int unsigned TRIG_W   = FRAC_BITS + 2;      // signed sine / cosine
  localparam int unsigned ROT_W    = COORD_W + TRIG_W;   // one rotation product
  localparam int unsigned SCALE_W  = 2 * COORD_W;        // one scale product
  localparam int unsigned WIDE_W   = 2 * COORD_W + 2;    // headroom for sums and rounding
  localparam int unsigned IDXMUL_W = QUARTER_BITS + IDX_W;

  // pi/2 in Q2.30, and the Taylor divisors (2n)(2n+1) for n = 1..7
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [6:0][7:0] TAYLOR_DIV = {
    8'd210, 8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6
  };

  // Command codes; 6 and 7 are unused and leave the point alone
  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD      = 3'd0,
    FUNC_ROT_X     = 3'd1,
    FUNC_ROT_Y     = 3'd2,
    FUNC_ROT_Z     = 3'd3,
    FUNC_SCALE     = 3'd4,
    FUNC_TRANSLATE = 3'd5
  } func_e;

  typedef logic [SINE_TABLE_DEPTH:0][SINE_W-1:0] sine_lut_t;

  // One saturated component and its clip flag
  typedef struct packed {
    logic                      clipped;
    logic signed [COORD_W-1:0] value;
  } clip_t;

  // Quarter-wave table, entry k = sin(pi/2 * k / depth), evaluated at elaboration
  function automatic sine_lut_t build_sine_lut();
    sine_lut_t          lut;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic signed [63:0] rnd;
    for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
      x    = (HALF_PI_Q30 * 64'(k)) / 64'(SINE_TABLE_DEPTH);
      x2   = (x * x) >> 30;
      term = x;
      sum  = signed'(x);
      for (int n = 1; n <= 7; n++) begin
        term = (term * x2) >> 30;
        term = term / 64'(TAYLOR_DIV[n-1]);
        if (n[0]) begin
          sum = sum - signed'(term);
        end else begin
          sum = sum + signed'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      if (sum > (64'sd1 <<< 30)) begin
        sum = 64'sd1 <<< 30;
      end
      rnd    = (sum + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
      lut[k] = rnd[SINE_W-1:0];
    end
    return lut;
  endfunction

  localparam sine_lut_t SINE_LUT = build_sine_lut();

  // Signed sine of a binary angle (65536 units per turn)
  function automatic logic signed [TRIG_W-1:0] sine_of(logic [ANGLE_W-1:0] a);
    logic [1:0]              quad;
    logic [QUARTER_BITS-1:0] ofs;
    logic [IDXMUL_W-1:0]     scaled;
    logic [IDX_W-1:0]        i;
    logic [IDX_W-1:0]        idx;
    logic [SINE_W-1:0]       mag;
    quad   = a[ANGLE_W-1 -: 2];
    ofs    = a[QUARTER_BITS-1:0];
    scaled = IDXMUL_W'(ofs) * IDXMUL_W'(SINE_TABLE_DEPTH);
    i      = scaled[QUARTER_BITS +: IDX_W];
    idx    = quad[0] ? (IDX_W'(SINE_TABLE_DEPTH) - i) : i;
    mag    = SINE_LUT[idx];
    return quad[1] ? -signed'({1'b0, mag}) : signed'({1'b0, mag});
  endfunction

endpackage

`default_nettype wire

### design/point_affine_transform_3d_core.sv
// ----------------------------------------------------------------------------
// point_affine_transform_3d_core: 3D point rotate / scale / translate engine
// Holds one Q16.16 point and applies one command per request: load, rotate
// about X, Y or Z, per-axis scale or per-axis translate, with rounding and
// saturation. Every command returns the updated point.
// ----------------------------------------------------------------------------
//  channel   | dir | tdata (low bit up)                 | tuser
//  s_axis    | in  | in_x[31:0] in_y[31:0] in_z[31:0]   | func[2:0]
//            |     | angle[15:0]                        |
//  m_axis    | out | pos_x[31:0] pos_y[31:0] pos_z[31:0]| saturated[0]
//
//  One command per cycle sustained while the result side is not stalled; a
//  request passes the input register, then the point/result register.
//  The cycle is set by the table lookup, the four rotation multipliers and
//  the add/round/clip path that feeds the point register.
//  rst_ni clears the point to zero and empties both stages.
//  A stalled result holds; a new request still enters an empty input register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module point_affine_transform_3d_core (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [111:0] s_axis_tdata,   // in_x, in_y, in_z, angle
  input  wire logic [2:0]   s_axis_tuser,   // func
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [95:0]       m_axis_tdata,   // pos_x, pos_y, pos_z
  output logic [0:0]        m_axis_tuser    // saturated
);
  import pat3d_pkg::*;

  // Input stage
  logic                      in_valid_q;
  logic [FUNC_W-1:0]         func_q;
  logic signed [COORD_W-1:0] in_x_q, in_y_q, in_z_q;
  logic [ANGLE_W-1:0]        angle_q;

  // Point state doubles as the result register
  logic                      out_valid_q;
  logic signed [COORD_W-1:0] point_x_q, point_y_q, point_z_q;
  logic signed [COORD_W-1:0] point_x_d, point_y_d, point_z_d;
  logic                      sat_q, sat_d;

  logic advance;
  logic fire;

  // Round half up by FRAC_BITS, then saturate to 32 bits
  function automatic clip_t round_clip(logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] w;
    logic signed [WIDE_W-1:0] r;
    clip_t                    res;
    w = v + (WIDE_W'(1) <<< (FRAC_BITS - 1));
    r = w >>> FRAC_BITS;
    if (r > WIDE_W'(signed'({1'b0, {(COORD_W-1){1'b1}}}))) begin
      res.clipped = 1'b1;
      res.value   = {1'b0, {(COORD_W-1){1'b1}}};
    end else if (r < -(WIDE_W'(1) <<< (COORD_W - 1))) begin
      res.clipped = 1'b1;
      res.value   = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      res.clipped = 1'b0;
      res.value   = r[COORD_W-1:0];
    end
    return res;
  endfunction

  // Saturate a 33-bit sum to 32 bits
  function automatic clip_t sum_clip(logic signed [COORD_W:0] v);
    clip_t res;
    res.clipped = (v[COORD_W] != v[COORD_W-1]);
    if (res.clipped) begin
      res.value = {v[COORD_W], {(COORD_W-1){~v[COORD_W]}}};
    end else begin
      res.value = v[COORD_W-1:0];
    end
    return res;
  endfunction

  // Handshake: the input stage moves on when the result slot is free
  assign advance       = !out_valid_q || m_axis_tready;
  assign fire          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_x_q  <= s_axis_tdata[31:0];
      in_y_q  <= s_axis_tdata[63:32];
      in_z_q  <= s_axis_tdata[95:64];
      angle_q <= s_axis_tdata[111:96];
      func_q  <= s_axis_tuser;
    end
  end

  // Sine and cosine from the quarter-wave table
  logic signed [TRIG_W-1:0] sin_v, cos_v;
  assign sin_v = sine_of(angle_q);
  assign cos_v = sine_of(angle_q + ANGLE_W'(1 << QUARTER_BITS));

  // Rotation operands: first = u*c - v*s, second = u*s + v*c
  logic signed [COORD_W-1:0] rot_u, rot_v;
  always_comb begin
    unique case (func_q)
      FUNC_ROT_X: begin
        rot_u = point_y_q;
        rot_v = point_z_q;
      end
      FUNC_ROT_Y: begin
        rot_u = point_z_q;
        rot_v = point_x_q;
      end
      default: begin
        rot_u = point_x_q;
        rot_v = point_y_q;
      end
    endcase
  end

  logic signed [ROT_W-1:0] prod_uc, prod_vs, prod_us, prod_vc;
  assign prod_uc = ROT_W'(rot_u) * ROT_W'(cos_v);
  assign prod_vs = ROT_W'(rot_v) * ROT_W'(sin_v);
  assign prod_us = ROT_W'(rot_u) * ROT_W'(sin_v);
  assign prod_vc = ROT_W'(rot_v) * ROT_W'(cos_v);

  clip_t rot_first, rot_second;
  assign rot_first  = round_clip(WIDE_W'(prod_uc) - WIDE_W'(prod_vs));
  assign rot_second = round_clip(WIDE_W'(prod_us) + WIDE_W'(prod_vc));

  // Per-axis scale
  logic signed [SCALE_W-1:0] scl_px, scl_py, scl_pz;
  assign scl_px = SCALE_W'(point_x_q) * SCALE_W'(in_x_q);
  assign scl_py = SCALE_W'(point_y_q) * SCALE_W'(in_y_q);
  assign scl_pz = SCALE_W'(point_z_q) * SCALE_W'(in_z_q);

  clip_t scl_x, scl_y, scl_z;
  assign scl_x = round_clip(WIDE_W'(scl_px));
  assign scl_y = round_clip(WIDE_W'(scl_py));
  assign scl_z = round_clip(WIDE_W'(scl_pz));

  // Per-axis translate
  clip_t trn_x, trn_y, trn_z;
  assign trn_x = sum_clip((COORD_W+1)'(point_x_q) + (COORD_W+1)'(in_x_q));
  assign trn_y = sum_clip((COORD_W+1)'(point_y_q) + (COORD_W+1)'(in_y_q));
  assign trn_z = sum_clip((COORD_W+1)'(point_z_q) + (COORD_W+1)'(in_z_q));

  // Next point by command
  always_comb begin
    point_x_d = point_x_q;
    point_y_d = point_y_q;
    point_z_d = point_z_q;
    sat_d     = 1'b0;
    unique case (func_q)
      FUNC_LOAD: begin
        point_x_d = in_x_q;
        point_y_d = in_y_q;
        point_z_d = in_z_q;
      end
      FUNC_ROT_X: begin
        point_y_d = rot_first.value;
        point_z_d = rot_second.value;
        sat_d     = rot_first.clipped | rot_second.clipped;
      end
      FUNC_ROT_Y: begin
        point_z_d = rot_first.value;
        point_x_d = rot_second.value;
        sat_d     = rot_first.clipped | rot_second.clipped;
      end
      FUNC_ROT_Z: begin
        point_x_d = rot_first.value;
        point_y_d = rot_second.value;
        sat_d     = rot_first.clipped | rot_second.clipped;
      end
      FUNC_SCALE: begin
        point_x_d = scl_x.value;
        point_y_d = scl_y.value;
        point_z_d = scl_z.value;
        sat_d     = scl_x.clipped | scl_y.clipped | scl_z.clipped;
      end
      FUNC_TRANSLATE: begin
        point_x_d = trn_x.value;
        point_y_d = trn_y.value;
        point_z_d = trn_z.value;
        sat_d     = trn_x.clipped | trn_y.clipped | trn_z.clipped;
      end
      default: begin
        sat_d = 1'b0;
      end
    endcase
  end

  // Point and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      point_x_q   <= '0;
      point_y_q   <= '0;
      point_z_q   <= '0;
      sat_q       <= 1'b0;
    end else begin
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
      if (fire) begin
        point_x_q <= point_x_d;
        point_y_q <= point_y_d;
        point_z_q <= point_z_d;
        sat_q     <= sat_d;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {point_z_q, point_y_q, point_x_q};
  assign m_axis_tuser  = sat_q;

  // Assertions
  a_load_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && func_q == FUNC_LOAD |=> !sat_q && point_x_q == $past(in_x_q))
    else $error("load did not take the point or flagged saturation");

  a_rotx_axis: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && func_q == FUNC_ROT_X |=> point_x_q == $past(point_x_q))
    else $error("rotation about X changed x");

  a_point_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire |=> $stable(point_x_q) && $stable(point_y_q) && $stable(point_z_q))
    else $error("point changed without a command");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(func_q) && $stable(in_x_q))
    else $error("held request lost while result stalled");

  a_unused_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && !(func_q == FUNC_LOAD || func_q == FUNC_ROT_X || func_q == FUNC_ROT_Y ||
              func_q == FUNC_ROT_Z || func_q == FUNC_SCALE || func_q == FUNC_TRANSLATE)
    |=> !sat_q && $stable(point_x_q) && $stable(point_z_q))
    else $error("unused command changed the point");

endmodule

`default_nettype wire

### test/point_transform_checker.sv
// ----------------------------------------------------------------------------
// point_transform_checker: result predictor and scoreboard for the 3D point
// transform core
// Watches both stream channels. Every accepted request is run through a local
// model of the point (own sine table, rounding and saturation) and the new
// point is queued; every accepted result is compared field by field with the
// oldest queued point.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module point_transform_checker (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  input  wire logic         s_axis_tready,
  input  wire logic [111:0] s_axis_tdata,   // in_x, in_y, in_z, angle
  input  wire logic [2:0]   s_axis_tuser,   // func
  input  wire logic         m_axis_tvalid,
  input  wire logic         m_axis_tready,
  input  wire logic [95:0]  m_axis_tdata,   // pos_x, pos_y, pos_z
  input  wire logic [0:0]   m_axis_tuser,   // saturated
  output int                fail_count_o,
  output int                pending_o
);
  import pat3d_pkg::*;

  localparam longint COORD_MAX = 64'sd2147483647;
  localparam longint COORD_MIN = -64'sd2147483648;
  localparam longint unsigned HALF_PI_FIX = 64'd1686629713;  // pi/2, 30 fraction bits

  typedef struct packed {
    logic                      sat;
    logic signed [COORD_W-1:0] z;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } point_result_t;

  // Model state: the point as the core should hold it
  logic signed [COORD_W-1:0] cur_x;
  logic signed [COORD_W-1:0] cur_y;
  logic signed [COORD_W-1:0] cur_z;

  longint        quarter_sine [0:SINE_TABLE_DEPTH];
  point_result_t expected_points [$];
  point_result_t want;
  int            fails = 0;

  // Quarter-wave sine table, Taylor series in Q2.30 then rounded to FRAC_BITS
  initial begin
    longint unsigned ang_fix;
    longint unsigned ang_sq;
    longint unsigned term;
    longint          acc;
    for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
      ang_fix = (HALF_PI_FIX * longint'(k)) / longint'(SINE_TABLE_DEPTH);
      ang_sq  = (ang_fix * ang_fix) >> 30;
      term    = ang_fix;
      acc     = longint'(ang_fix);
      for (int n = 1; n <= 7; n++) begin
        term = (term * ang_sq) >> 30;
        term = term / longint'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) begin
          acc = acc - longint'(term);
        end else begin
          acc = acc + longint'(term);
        end
      end
      if (acc < 0) begin
        acc = 0;
      end
      if (acc > (64'sd1 <<< 30)) begin
        acc = 64'sd1 <<< 30;
      end
      quarter_sine[k] = (acc + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
    end
  end

  // Signed sine of a binary angle, folded onto the quarter table
  function automatic longint sine_lookup(input logic [ANGLE_W-1:0] a);
    int     idx;
    longint mag;
    idx = (int'(a[QUARTER_BITS-1:0]) * SINE_TABLE_DEPTH) >> QUARTER_BITS;
    mag = a[ANGLE_W-2] ? quarter_sine[SINE_TABLE_DEPTH - idx] : quarter_sine[idx];
    return a[ANGLE_W-1] ? -mag : mag;
  endfunction

  // Divide by 2^FRAC_BITS, ties toward plus infinity
  function automatic longint round_q(input longint v);
    return (v + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
  endfunction

  function automatic clip_t clamp_coord(input longint v);
    clip_t r;
    r.clipped = 1'b1;
    if (v > COORD_MAX) begin
      r.value = COORD_MAX[COORD_W-1:0];
    end else if (v < COORD_MIN) begin
      r.value = COORD_MIN[COORD_W-1:0];
    end else begin
      r.clipped = 1'b0;
      r.value   = v[COORD_W-1:0];
    end
    return r;
  endfunction

  // Apply one command to the model point and return the point it yields.
  // Rotations use only the components from before the command.
  function automatic point_result_t predict_command(input logic [FUNC_W-1:0] f,
                                                    input logic [111:0] req);
    longint        px;
    longint        py;
    longint        pz;
    longint        ix;
    longint        iy;
    longint        iz;
    longint        sn;
    longint        cs;
    clip_t         rx;
    clip_t         ry;
    clip_t         rz;
    point_result_t res;
    px = cur_x;
    py = cur_y;
    pz = cur_z;
    ix = longint'($signed(req[31:0]));
    iy = longint'($signed(req[63:32]));
    iz = longint'($signed(req[95:64]));
    sn = sine_lookup(req[111:96]);
    cs = sine_lookup(req[111:96] + 16'd16384);
    rx.clipped = 1'b0;
    rx.value   = cur_x;
    ry.clipped = 1'b0;
    ry.value   = cur_y;
    rz.clipped = 1'b0;
    rz.value   = cur_z;
    case (f)
      FUNC_LOAD: begin
        rx.value = req[31:0];
        ry.value = req[63:32];
        rz.value = req[95:64];
      end
      FUNC_ROT_X: begin
        ry = clamp_coord(round_q(py * cs - pz * sn));
        rz = clamp_coord(round_q(py * sn + pz * cs));
      end
      FUNC_ROT_Y: begin
        rx = clamp_coord(round_q(px * cs + pz * sn));
        rz = clamp_coord(round_q(pz * cs - px * sn));
      end
      FUNC_ROT_Z: begin
        rx = clamp_coord(round_q(px * cs - py * sn));
        ry = clamp_coord(round_q(px * sn + py * cs));
      end
      FUNC_SCALE: begin
        rx = clamp_coord(round_q(px * ix));
        ry = clamp_coord(round_q(py * iy));
        rz = clamp_coord(round_q(pz * iz));
      end
      FUNC_TRANSLATE: begin
        rx = clamp_coord(px + ix);
        ry = clamp_coord(py + iy);
        rz = clamp_coord(pz + iz);
      end
      default: ;  // spare codes hold the point
    endcase
    cur_x = rx.value;
    cur_y = ry.value;
    cur_z = rz.value;
    res.x   = rx.value;
    res.y   = ry.value;
    res.z   = rz.value;
    res.sat = rx.clipped | ry.clipped | rz.clipped;
    return res;
  endfunction

  // Results are matched before new requests, so a result can never be paired
  // with a request taken on the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x = '0;
      cur_y = '0;
      cur_z = '0;
      expected_points.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_points.size() == 0) begin
          $error("result with no request outstanding: pos_x %0d pos_y %0d pos_z %0d",
                 $signed(m_axis_tdata[31:0]), $signed(m_axis_tdata[63:32]),
                 $signed(m_axis_tdata[95:64]));
          fails++;
        end else begin
          want = expected_points.pop_front();
          if (want.x !== $signed(m_axis_tdata[31:0])) begin
            $error("pos_x mismatch: expected %0d, actual %0d",
                   want.x, $signed(m_axis_tdata[31:0]));
            fails++;
          end
          if (want.y !== $signed(m_axis_tdata[63:32])) begin
            $error("pos_y mismatch: expected %0d, actual %0d",
                   want.y, $signed(m_axis_tdata[63:32]));
            fails++;
          end
          if (want.z !== $signed(m_axis_tdata[95:64])) begin
            $error("pos_z mismatch: expected %0d, actual %0d",
                   want.z, $signed(m_axis_tdata[95:64]));
            fails++;
          end
          if (want.sat !== m_axis_tuser[0]) begin
            $error("saturated mismatch: expected %0d, actual %0d", want.sat, m_axis_tuser[0]);
            fails++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expected_points.push_back(predict_command(s_axis_tuser, s_axis_tdata));
      end
    end
    fail_count_o <= fails;
    pending_o    <= expected_points.size();
  end

endmodule

### test/testbench.sv
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the 3D point transform core
// Drives a directed set of commands (field extremes, every command, quadrant
// angles, rounding ties, saturation both ways, spare codes), then random
// command streams with random idle bursts on both channels. The checker
// instance predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import pat3d_pkg::*;

  localparam int RANDOM_ITEMS   = 900;
  localparam int QUIET_TAIL     = 150;   // last requests run with no idling
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with nothing accepted

  // Spare command codes, decoded as no-ops by the core
  localparam logic [FUNC_W-1:0] FUNC_SPARE_6 = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_SPARE_7 = 3'd7;

  localparam logic [31:0] Q_MAX  = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN  = 32'h8000_0000;
  localparam logic [31:0] Q_ONE  = 32'h0001_0000;
  localparam logic [31:0] Q_NEG1 = 32'hFFFF_FFFF;

  localparam int SPREAD_FULL  = 0;
  localparam int SPREAD_SMALL = 1;
  localparam int SPREAD_UNITY = 2;

  logic         clk_i;
  logic         rst_ni        = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [111:0] s_axis_tdata  = '0;   // in_x, in_y, in_z, angle
  logic [2:0]   s_axis_tuser  = '0;   // func
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [95:0]  m_axis_tdata;         // pos_x, pos_y, pos_z
  logic [0:0]   m_axis_tuser;         // saturated

  logic         idle_on = 1'b1;
  int           fail_count;
  int           pending_results;

  point_affine_transform_3d_core u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  point_transform_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .fail_count_o (fail_count),
    .pending_o    (pending_results)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Result side back-pressure: random stall bursts
  always @(posedge clk_i) begin
    int unsigned hold_cycles;
    if (hold_cycles != 0) begin
      hold_cycles = hold_cycles - 1;
      m_axis_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      hold_cycles = $urandom_range(0, 3);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Watchdog: too long without any transfer on either channel
  always @(posedge clk_i) begin
    int unsigned quiet_cycles;
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Random gap after a request
  task automatic sender_gap();
    if (idle_on && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  // Present one command and hold it until the core takes it
  task automatic send_cmd(input logic [FUNC_W-1:0] f, input logic [31:0] x,
                          input logic [31:0] y, input logic [31:0] z,
                          input logic [15:0] ang);
    s_axis_tuser  <= f;
    s_axis_tdata  <= {ang, z, y, x};
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sender_gap();
  endtask

  function automatic logic [31:0] pick_coord(input int spread);
    logic [31:0] v;
    logic [31:0] mag;
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 3))
        0:       v = Q_MAX;
        1:       v = Q_MIN;
        2:       v = '0;
        default: v = Q_NEG1;
      endcase
    end else if (spread == SPREAD_SMALL) begin
      v = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
    end else if (spread == SPREAD_UNITY) begin
      // magnitude 0.5 .. 1.5, either sign
      mag = 32'h0000_8000 + $urandom_range(0, 32'h0001_0000);
      v   = $urandom_range(0, 1) ? -mag : mag;
    end else begin
      v = $urandom;
    end
    return v;
  endfunction

  function automatic logic [FUNC_W-1:0] pick_func();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 14) return FUNC_LOAD;
    if (r < 31) return FUNC_ROT_X;
    if (r < 48) return FUNC_ROT_Y;
    if (r < 65) return FUNC_ROT_Z;
    if (r < 79) return FUNC_SCALE;
    if (r < 96) return FUNC_TRANSLATE;
    return (r < 98) ? FUNC_SPARE_6 : FUNC_SPARE_7;
  endfunction

  // Mostly any angle; some land on or right beside an eighth of a turn
  function automatic logic [15:0] pick_angle();
    if ($urandom_range(0, 4) == 0) begin
      return 16'($urandom_range(0, 7) * 8192 + $urandom_range(0, 2) - 1);
    end
    return 16'($urandom);
  endfunction

  initial begin
    logic [FUNC_W-1:0] f;
    logic [31:0]       x;
    logic [31:0]       y;
    logic [31:0]       z;
    logic [15:0]       ang;
    int                spread;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: extremes, quadrant angles, clipping, rounding ties, spare codes
    send_cmd(FUNC_LOAD,      Q_MAX, Q_MIN, Q_NEG1, 16'h0000);
    send_cmd(FUNC_ROT_X,     '0, '0, '0, 16'h0000);
    send_cmd(FUNC_LOAD,      Q_ONE, 32'h0002_0000, 32'hFFFD_0000, 16'hFFFF);
    send_cmd(FUNC_ROT_X,     Q_NEG1, Q_NEG1, Q_NEG1, 16'h4000);
    send_cmd(FUNC_ROT_Y,     '0, '0, '0, 16'h8000);
    send_cmd(FUNC_ROT_Z,     '0, '0, '0, 16'hFFFF);
    send_cmd(FUNC_ROT_Z,     '0, '0, '0, 16'h7FFF);
    send_cmd(FUNC_ROT_Y,     '0, '0, '0, 16'h2000);
    send_cmd(FUNC_ROT_X,     '0, '0, '0, 16'hC000);
    send_cmd(FUNC_SCALE,     32'h0001_8000, Q_MIN, Q_MAX, 16'h0000);
    send_cmd(FUNC_LOAD,      Q_MAX, Q_MAX, Q_MAX, 16'h0000);
    send_cmd(FUNC_ROT_X,     '0, '0, '0, 16'h2000);
    send_cmd(FUNC_ROT_Z,     '0, '0, '0, 16'h6000);
    send_cmd(FUNC_LOAD,      Q_MIN, Q_MIN, Q_MIN, 16'h0000);
    send_cmd(FUNC_SCALE,     Q_MIN, Q_MIN, Q_MIN, 16'h0000);
    send_cmd(FUNC_TRANSLATE, Q_MAX, Q_MAX, Q_MAX, 16'h0000);
    send_cmd(FUNC_TRANSLATE, Q_MIN, Q_MIN, Q_MIN, 16'h0000);
    send_cmd(FUNC_TRANSLATE, Q_MIN, Q_MIN, Q_MIN, 16'h0000);
    send_cmd(FUNC_SPARE_6,   Q_NEG1, Q_NEG1, Q_NEG1, 16'hFFFF);
    send_cmd(FUNC_SPARE_7,   Q_MIN, Q_MAX, '0, 16'h8000);
    // half-unit ties round toward plus infinity
    send_cmd(FUNC_LOAD,      32'h0000_8000, 32'hFFFF_8000, Q_NEG1, 16'h5555);
    send_cmd(FUNC_SCALE,     32'd1, 32'd1, 32'd1, 16'h0000);
    send_cmd(FUNC_LOAD,      32'h0003_0000, 32'hFFFB_0000, 32'h0007_4000, 16'h0000);
    send_cmd(FUNC_ROT_Y,     '0, '0, '0, 16'h4000);
    send_cmd(FUNC_ROT_Z,     '0, '0, '0, 16'hA000);

    // Random command stream
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      idle_on <= (n < RANDOM_ITEMS - QUIET_TAIL) && ((n / 120) % 4 != 3);
      if (n == RANDOM_ITEMS / 2) begin
        // hold off until the core has returned every result
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
        while (pending_results != 0) @(posedge clk_i);
      end
      f = pick_func();
      case (f)
        FUNC_LOAD:      spread = $urandom_range(0, 1) ? SPREAD_SMALL : SPREAD_FULL;
        FUNC_SCALE:     spread = ($urandom_range(0, 9) < 7) ? SPREAD_UNITY : SPREAD_FULL;
        FUNC_TRANSLATE: spread = ($urandom_range(0, 9) < 7) ? SPREAD_SMALL : SPREAD_FULL;
        default:        spread = SPREAD_FULL;
      endcase
      x   = pick_coord(spread);
      y   = pick_coord(spread);
      z   = pick_coord(spread);
      ang = pick_angle();
      send_cmd(f, x, y, z, ang);
    end
    s_axis_tvalid <= 1'b0;

    // Drain, then allow the two-stage pipe to settle
    @(posedge clk_i);
    while (pending_results != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
